@@ hdl/sui_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_pkg: shared types for the sort and deduplicate block
// Controller states, command and status groups, fixed port widths.
// ----------------------------------------------------------------------------
package sui_pkg;

	localparam int IDX_W = 24;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_EMIT,
		ST_EMPTY
	} sui_state_t;

	typedef struct packed {
		logic insert;
		logic close;
		logic pop;
		logic load_empty;
	} sui_cmd_t;

	typedef struct packed {
		logic close_zero;
		logic rem_one;
		logic out_free;
	} sui_status_t;

endpackage

@@ hdl/sui_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_ctrl: sequencer for collect and emit phases
// Accepts requests while collecting, then steps the emit of one set.
// ----------------------------------------------------------------------------
module sui_ctrl
	import sui_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        close_set,
	input  logic        has_index,
	input  sui_status_t status,
	output sui_cmd_t    cmd
);

	sui_state_t state_q, state_d;
	logic       accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (accept && close_set) begin
					state_d = status.close_zero ? ST_EMPTY : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.rem_one) begin
					state_d = ST_COLLECT;
				end
			end
			ST_EMPTY: begin
				if (status.out_free) begin
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd.insert     = 1'b0;
		cmd.close      = 1'b0;
		cmd.pop        = 1'b0;
		cmd.load_empty = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				in_ready   = 1'b1;
				cmd.insert = accept && has_index;
				cmd.close  = accept && close_set;
			end
			ST_EMIT: begin
				cmd.pop = status.out_free;
			end
			ST_EMPTY: begin
				cmd.load_empty = status.out_free;
			end
			default: in_ready = 1'b0;
		endcase
	end

endmodule

@@ hdl/sui_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_datapath: insertion sorter row and result register
// Sorted row of cells drops duplicates on insert, shifts out on emit.
// ----------------------------------------------------------------------------
module sui_datapath
	import sui_pkg::*;
#(
	parameter int STORE_DEPTH = 64,
	parameter int INDEX_BITS  = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 has_index,
	input  logic [IDX_W-1:0]     row_index,
	input  sui_cmd_t             cmd,
	output sui_status_t          status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_W-1:0]     unique_index,
	output logic [CNT_OUT_W-1:0] unique_count,
	output logic                 empty_set,
	output logic                 overflowed,
	output logic                 last_result
);

	localparam int KEEP_W = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(STORE_DEPTH);

	logic [KEEP_W-1:0]      cell_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] gt, eq;
	logic [KEEP_W-1:0]      key;
	logic [CNT_W-1:0]       dcnt_q, raw_q, uniq_q, rem_q, dcnt_next;
	logic                   ovf_q, ovf_set_q, ovf_next;
	logic                   raw_full, do_ins, dup;

	logic                 out_valid_q;
	logic [KEEP_W-1:0]    out_index_q;
	logic [CNT_W-1:0]     out_count_q;
	logic                 out_empty_q, out_ovf_q, out_last_q;

	assign key      = row_index[KEEP_W-1:0];
	assign raw_full = (raw_q == FULL);
	assign dup      = |eq;
	assign do_ins   = cmd.insert && !raw_full && !dup;
	assign dcnt_next = do_ins ? dcnt_q + CNT_W'(1) : dcnt_q;
	assign ovf_next  = ovf_q || (cmd.insert && raw_full);

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		assign gt[i] = (CNT_W'(i) >= dcnt_q) || (cell_q[i] > key);
		assign eq[i] = (CNT_W'(i) < dcnt_q) && (cell_q[i] == key);

		always_ff @(posedge clk) begin
			if (do_ins && gt[i]) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
				end else begin
					cell_q[i] <= key;
				end
			end else if (cmd.pop && i < STORE_DEPTH - 1) begin
				cell_q[i] <= cell_q[(i < STORE_DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q    <= '0;
			raw_q     <= '0;
			ovf_q     <= 1'b0;
			uniq_q    <= '0;
			rem_q     <= '0;
			ovf_set_q <= 1'b0;
		end else begin
			if (cmd.close) begin
				dcnt_q    <= '0;
				raw_q     <= '0;
				ovf_q     <= 1'b0;
				uniq_q    <= dcnt_next;
				rem_q     <= dcnt_next;
				ovf_set_q <= ovf_next;
			end else begin
				dcnt_q <= dcnt_next;
				ovf_q  <= ovf_next;
				if (cmd.insert && !raw_full) begin
					raw_q <= raw_q + CNT_W'(1);
				end
				if (cmd.pop) begin
					rem_q <= rem_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop || cmd.load_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_index_q <= cell_q[0];
			out_count_q <= uniq_q;
			out_empty_q <= 1'b0;
			out_ovf_q   <= ovf_set_q;
			out_last_q  <= (rem_q == CNT_W'(1));
		end else if (cmd.load_empty) begin
			out_index_q <= '0;
			out_count_q <= '0;
			out_empty_q <= 1'b1;
			out_ovf_q   <= ovf_set_q;
			out_last_q  <= 1'b1;
		end
	end

	assign status.close_zero = (dcnt_q == '0) && !has_index;
	assign status.rem_one    = (rem_q == CNT_W'(1));
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign unique_index = IDX_W'(out_index_q);
	assign unique_count = CNT_OUT_W'(out_count_q);
	assign empty_set    = out_empty_q;
	assign overflowed   = out_ovf_q;
	assign last_result  = out_last_q;

	a_dcnt_le_raw: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= raw_q)
		else $error("distinct count exceeds raw count");

	a_raw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		raw_q <= FULL)
		else $error("raw count beyond store depth");

	a_pop_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> rem_q != '0)
		else $error("emit with nothing remaining");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> (dcnt_q == '0) && (raw_q == '0) && !ovf_q)
		else $error("set state not cleared after close");

endmodule

@@ hdl/sort_unique_indices.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_unique_indices: sort and deduplicate one set of row indices
// Indices are inserted into a sorted cell row as they arrive; a close
// request starts an in-order emit of the distinct indices.
// ----------------------------------------------------------------------------
// Collect: one request per cycle, each index placed in sorted order on entry.
// Emit: the close moves the controller to emit, which loads the first result
// into the output register, then one per cycle as taken, bounded by the single
// shift-out port of the cell row; requests wait until the last one is loaded.
// Reset clears counts, flags and handshake state; cell contents are not reset.
// ----------------------------------------------------------------------------
module sort_unique_indices
	import sui_pkg::*;
#(
	parameter int STORE_DEPTH = 64,
	parameter int INDEX_BITS  = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 has_index,
	input  logic [IDX_W-1:0]     row_index,
	input  logic                 close_set,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_W-1:0]     unique_index,
	output logic [CNT_OUT_W-1:0] unique_count,
	output logic                 empty_set,
	output logic                 overflowed,
	output logic                 last_result
);

	sui_cmd_t    cmd;
	sui_status_t status;

	sui_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.close_set (close_set),
		.has_index (has_index),
		.status    (status),
		.cmd       (cmd)
	);

	sui_datapath #(
		.STORE_DEPTH (STORE_DEPTH),
		.INDEX_BITS  (INDEX_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.has_index    (has_index),
		.row_index    (row_index),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.unique_index (unique_index),
		.unique_count (unique_count),
		.empty_set    (empty_set),
		.overflowed   (overflowed),
		.last_result  (last_result)
	);

endmodule

@@ bench/sort_unique_indices_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_unique_indices_test: self-checking bench for the sort/dedup block
// Sends sets of row indices through the request channel, keeps its own
// sorted set of distinct indices per column, and checks every result field
// against it. Covers empty sets, extreme indices, full store, store overflow,
// a long receiver hold-off and random sets with random source/sink idling.
// ----------------------------------------------------------------------------
module sort_unique_indices_test
	import sui_pkg::*;
();

	localparam int STORE_DEPTH = 64;
	localparam int INDEX_BITS = 24;
	localparam logic [IDX_W-1:0] KEEP_MASK = IDX_W'((64'd1 << INDEX_BITS) - 1);
	localparam logic [IDX_W-1:0] MAX_INDEX = '1;
	localparam int unsigned TARGET_REQUESTS = 380;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned MAX_PRINTED = 40;

	typedef enum logic {SINK_FREE, SINK_PATTERN} sink_mode_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [CNT_OUT_W-1:0] count;
		logic empty;
		logic ovf;
		logic last;
	} unique_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic has_index;
	logic [IDX_W-1:0] row_index;
	logic close_set;
	logic out_valid;
	logic out_ready;
	logic [IDX_W-1:0] unique_index;
	logic [CNT_OUT_W-1:0] unique_count;
	logic empty_set;
	logic overflowed;
	logic last_result;

	unique_result_t pending_unique[$];
	bit column_members[bit [IDX_W-1:0]];
	int unsigned column_fill;
	bit column_overflow;

	int unsigned error_count;
	int unsigned requests_sent;
	int unsigned cycle_count;
	int unsigned burst_left;
	bit src_gaps;
	sink_mode_t sink_mode;
	logic [15:0] ready_pattern;
	int unsigned pattern_pos;
	int unsigned hold_request;
	int unsigned hold_left;

	sort_unique_indices #(
		.STORE_DEPTH(STORE_DEPTH),
		.INDEX_BITS(INDEX_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.has_index(has_index),
		.row_index(row_index),
		.close_set(close_set),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.unique_index(unique_index),
		.unique_count(unique_count),
		.empty_set(empty_set),
		.overflowed(overflowed),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < MAX_PRINTED)
			$display("ERROR @%0t: %s got %0h expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Column model: distinct indices kept in an ordered map, emitted ascending.
	task automatic predict_unique_indices(input logic has, input logic [IDX_W-1:0] idx,
			input logic close);
		unique_result_t r;
		int unsigned distinct;
		int unsigned rank;
		if (has) begin
			if (column_fill < STORE_DEPTH) begin
				column_members[idx & KEEP_MASK] = 1'b1;
				column_fill++;
			end else begin
				column_overflow = 1'b1;
			end
		end
		if (close) begin
			if (column_fill == 0) begin
				r = '{index: '0, count: '0, empty: 1'b1, ovf: column_overflow, last: 1'b1};
				pending_unique.push_back(r);
			end else begin
				distinct = column_members.num();
				rank = 0;
				foreach (column_members[k]) begin
					rank++;
					r = '{index: k, count: CNT_OUT_W'(distinct), empty: 1'b0,
						ovf: column_overflow, last: rank == distinct};
					pending_unique.push_back(r);
				end
			end
			column_members.delete();
			column_fill = 0;
			column_overflow = 1'b0;
		end
	endtask

	// Results are checked before the same-edge request is folded into the model.
	always @(posedge clk) begin
		unique_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_unique.size() == 0) begin
					report_mismatch("result with nothing pending", 32'(unique_index), 32'd0);
				end else begin
					want = pending_unique.pop_front();
					if (unique_index !== want.index)
						report_mismatch("unique_index", 32'(unique_index), 32'(want.index));
					if (unique_count !== want.count)
						report_mismatch("unique_count", 32'(unique_count), 32'(want.count));
					if (empty_set !== want.empty)
						report_mismatch("empty_set", 32'(empty_set), 32'(want.empty));
					if (overflowed !== want.ovf)
						report_mismatch("overflowed", 32'(overflowed), 32'(want.ovf));
					if (last_result !== want.last)
						report_mismatch("last_result", 32'(last_result), 32'(want.last));
				end
			end
			if (in_valid && in_ready)
				predict_unique_indices(has_index, row_index, close_set);
		end
	end

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (sink_mode == SINK_FREE) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ready_pattern[pattern_pos % 16];
			pattern_pos++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic set_sink(input sink_mode_t mode);
		sink_mode = mode;
		ready_pattern = 16'($urandom) | 16'h0101;
	endtask

	task automatic send_request(input logic has, input logic [IDX_W-1:0] idx,
			input logic close);
		int unsigned gap;
		if (src_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left != 0)
			burst_left--;
		in_valid <= 1'b1;
		has_index <= has;
		row_index <= idx;
		close_set <= close;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	task automatic test_empty_sets();
		send_request(1'b0, '0, 1'b1);
		send_request(1'b0, MAX_INDEX, 1'b0);
		send_request(1'b0, 24'h5a5a5a, 1'b1);
	endtask

	task automatic test_extremes();
		send_request(1'b1, MAX_INDEX, 1'b0);
		send_request(1'b1, '0, 1'b0);
		send_request(1'b0, 24'h555555, 1'b0);
		send_request(1'b1, MAX_INDEX, 1'b0);
		send_request(1'b1, '0, 1'b1);
		send_request(1'b1, 24'haaaaaa, 1'b1);
		for (int i = 5; i >= 1; i--)
			send_request(1'b1, IDX_W'(i), 1'b0);
		send_request(1'b1, 24'd3, 1'b0);
		send_request(1'b0, '0, 1'b1);
		send_request(1'b1, 24'h800000, 1'b0);
		send_request(1'b1, 24'h7fffff, 1'b1);
	endtask

	task automatic test_full_store();
		for (int i = 0; i < STORE_DEPTH; i++)
			send_request(1'b1, MAX_INDEX - IDX_W'(i) * 24'h040000, i == STORE_DEPTH - 1);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < STORE_DEPTH; i++)
			send_request(1'b1, IDX_W'($urandom_range(0, 40)), 1'b0);
		send_request(1'b1, IDX_W'($urandom), 1'b0);
		send_request(1'b1, MAX_INDEX, 1'b0);
		send_request(1'b1, '0, 1'b1);
		send_request(1'b1, 24'h123456, 1'b1);
	endtask

	task automatic test_pressure();
		src_gaps = 1'b0;
		set_sink(SINK_FREE);
		hold_request = 400;
		for (int s = 0; s < 6; s++)
			for (int i = 0; i < 8; i++)
				send_request(1'b1, IDX_W'($urandom_range(0, 20)), i == 7);
	endtask

	task automatic test_random_sets();
		int unsigned set_len;
		int unsigned pick;
		int unsigned span;
		int unsigned sets_done;
		logic [IDX_W-1:0] base;
		logic [IDX_W-1:0] idx;
		logic close_has;
		sets_done = 0;
		while (requests_sent < TARGET_REQUESTS) begin
			if (sets_done % 6 == 0) begin
				src_gaps = $urandom_range(0, 3) != 0;
				if ($urandom_range(0, 3) == 0)
					set_sink(SINK_FREE);
				else
					set_sink(SINK_PATTERN);
			end
			pick = $urandom_range(0, 99);
			if (pick < 8)
				set_len = 0;
			else if (pick < 85)
				set_len = $urandom_range(1, 8);
			else if (pick < 97)
				set_len = $urandom_range(9, 24);
			else
				set_len = $urandom_range(25, STORE_DEPTH);
			case ($urandom_range(0, 2))
				0: span = 0;
				1: span = 7;
				default: span = 63;
			endcase
			base = IDX_W'($urandom);
			close_has = 1'($urandom_range(0, 1));
			for (int i = 0; i < set_len; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_request(1'b0, IDX_W'($urandom), 1'b0);
				if (span == 0)
					idx = IDX_W'($urandom);
				else
					idx = base + IDX_W'($urandom_range(0, span));
				send_request(1'b1, idx, close_has && i == set_len - 1);
			end
			if (set_len == 0 || !close_has)
				send_request(1'b0, IDX_W'($urandom), 1'b1);
			sets_done++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		has_index = 1'b0;
		row_index = '0;
		close_set = 1'b0;
		out_ready = 1'b0;
		error_count = 0;
		requests_sent = 0;
		cycle_count = 0;
		burst_left = 0;
		src_gaps = 1'b1;
		sink_mode = SINK_PATTERN;
		ready_pattern = 16'hb6d5;
		pattern_pos = 0;
		hold_request = 0;
		hold_left = 0;
		column_fill = 0;
		column_overflow = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_sets();
		test_extremes();
		test_full_store();
		test_overflow();
		test_pressure();
		test_random_sets();

		in_valid <= 1'b0;
		while (pending_unique.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_unique.size() != 0)
			report_mismatch("results left pending", 32'(pending_unique.size()), 32'd0);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
